FILE: sv/bpa_pkg.sv
// Shared codes, field widths and a helper function of the buddy page allocator.
package bpa_pkg;

    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 25;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // ceil(log2(n)), 0 for n <= 1
    function automatic logic [5:0] ceil_log2_32(input logic [31:0] n);
        logic [31:0] m;
        logic [5:0]  k;
        m = n - 32'd1;
        k = 6'd0;
        if (n > 32'd1) begin
            for (int i = 0; i < 32; i++) begin
                if (m[i]) k = 6'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

FILE: sv/bpa_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/buddy_page_allocator_core.sv
// Buddy page allocator: top level with control sequencer and free-list heads.
//
// Usage:
//   Input stream s_*: s_tuser = func (0 allocate, 1 free), s_tdata[31:0] =
//   request_bytes, s_tdata[63:32] = free_offset. One result per request on m_*:
//   m_tdata[2:0] = status, m_tdata[27:3] = block_offset.
//   Requests are processed one at a time; s_tready is high only while the
//   sequencer is idle. A request is taken while the previous result still sits
//   in the output register.
//   Sequence: a request rejected on decode goes straight to the DONE step, and
//   a free rejected on the page check goes there after FCHK. Allocate pops the
//   head in APOP, then takes one SPLIT step per split. Free checks the page in
//   FCHK; per merge level it checks the buddy (FBUD, FBCHK), visits free-list
//   nodes in USTEP and UWAIT while unlinking the buddy (the buddy included)
//   and merges in MERGE. A buddy check below the top order can end the merge;
//   the block then goes onto its list in PUSH. The walk over the next-link RAM
//   (one read per node) and the single read port of each RAM set the pace.
//   Reset: after aresetn, a clearing pass writes every page entry of both
//   RAMs with s_tready low. The whole region then is a single free block at
//   page 0.
//   Stall: when m_tready is low the finished result waits in the DONE step;
//   the output register holds its content until taken.
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int TOTAL_PAGES = 8192,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] request_bytes, [63:32] free_offset
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [2:0] status, [27:3] block_offset, [31:28] zero
);
    localparam int PW   = $clog2(TOTAL_PAGES);           // page index bits
    localparam int TOP  = $clog2(TOTAL_PAGES + 1) - 1;    // top relative order
    localparam int MAXO = PAGE_SHIFT + TOP;               // top absolute order
    localparam int OW   = $clog2(MAXO + 1);               // order field bits
    localparam int RW   = $clog2(TOP + 1);                // relative order bits
    localparam int MW   = OW + 1;                         // {free, order}
    localparam int LW   = PW + 1;                         // {valid, ptr}

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_APOP  = 4'd2;
    localparam logic [3:0] S_SPLIT = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FBUD  = 4'd5;
    localparam logic [3:0] S_FBCHK = 4'd6;
    localparam logic [3:0] S_USTEP = 4'd7;
    localparam logic [3:0] S_UWAIT = 4'd8;
    localparam logic [3:0] S_MERGE = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [PW-1:0]       clr_reg, clr_next;
    logic [PW-1:0]       head_reg [TOP+1];
    logic [PW-1:0]       head_next [TOP+1];
    logic [TOP:0]        hvalid_reg, hvalid_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [PW-1:0]       b_reg, b_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [PW-1:0]       prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic                ok_reg, ok_next;
    logic [PW:0]         steps_reg, steps_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [RW-1:0]       rel_reg, rel_next;
    logic                func_reg, func_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                mvalid_reg, mvalid_next;
    logic [31:0]         mdata_reg, mdata_next;

    // metadata RAM {free, order}, link RAM {valid, next page}
    logic          meta_we, link_we;
    logic [PW-1:0] meta_waddr, meta_raddr, link_waddr, link_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic [LW-1:0] link_wdata, link_rdata;

    bpa_ram #(.WIDTH(MW), .DEPTH(TOTAL_PAGES)) u_meta (
        .clk(aclk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(TOTAL_PAGES)) u_link (
        .clk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    // allocate and free decode
    logic [31:0]   req_bytes;
    logic [31:0]   free_off;
    logic [31:0]   free_page;
    logic [5:0]    ord_raw, ord_cl;
    logic [RW-1:0] rel_in;
    logic          found;
    logic [RW-1:0] r_found;
    logic [RW-1:0] r_dec;
    logic [PW-1:0] bud;
    logic [OW-1:0] meta_ord;
    logic          meta_free;
    logic [63:0]   off_wide;

    assign req_bytes = s_tdata[31:0];
    assign free_off  = s_tdata[63:32];
    assign free_page = free_off >> PAGE_SHIFT;
    assign ord_raw   = ceil_log2_32(req_bytes);
    assign ord_cl    = (ord_raw < 6'(PAGE_SHIFT)) ? 6'(PAGE_SHIFT) : ord_raw;
    assign rel_in    = RW'(ord_cl - 6'(PAGE_SHIFT));
    assign r_dec     = r_reg - RW'(1);
    assign meta_ord  = meta_rdata[OW-1:0];
    assign meta_free = meta_rdata[OW];
    assign off_wide  = 64'({p_reg, {PAGE_SHIFT{1'b0}}});

    // lowest non-empty order at or above the requested one
    always_comb begin
        found   = 1'b0;
        r_found = '0;
        for (int j = TOP; j >= 0; j--) begin
            if (RW'(j) >= rel_in && hvalid_reg[j]) begin
                found   = 1'b1;
                r_found = RW'(j);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        hvalid_next    = hvalid_reg;
        p_next         = p_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        ok_next        = ok_reg;
        steps_next     = steps_reg;
        r_next         = r_reg;
        rel_next       = rel_reg;
        func_next      = func_reg;
        status_next    = status_reg;
        mvalid_next    = mvalid_reg;
        mdata_next     = mdata_reg;
        meta_we        = 1'b0;
        meta_waddr     = p_reg;
        meta_wdata     = '0;
        meta_raddr     = p_reg;
        link_we        = 1'b0;
        link_waddr     = p_reg;
        link_wdata     = '0;
        link_raddr     = p_reg;
        bud            = p_reg ^ (PW'(1) << r_reg);

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = (clr_reg == '0) ? {1'b1, OW'(MAXO)} : '0;
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = '0;
                clr_next   = clr_reg + PW'(1);
                if (clr_reg == PW'(TOTAL_PAGES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next   = s_tuser;
                    status_next = ST_OK;
                    if (s_tuser == FUNC_ALLOC) begin
                        rel_next = rel_in;
                        r_next   = r_found;
                        p_next   = head_reg[r_found];
                        meta_raddr = head_reg[r_found];
                        link_raddr = head_reg[r_found];
                        priority if (req_bytes == 32'd0) begin
                            status_next = ST_ZERO_SIZE;
                            state_next  = S_DONE;
                        end else if (ord_cl > 6'(MAXO)) begin
                            status_next = ST_TOO_LARGE;
                            state_next  = S_DONE;
                        end else if (!found) begin
                            status_next = ST_NO_MEMORY;
                            state_next  = S_DONE;
                        end else begin
                            state_next  = S_APOP;
                        end
                    end else begin
                        p_next     = free_page[PW-1:0];
                        meta_raddr = free_page[PW-1:0];
                        if (free_page >= 32'(TOTAL_PAGES)) begin
                            status_next = ST_BAD_OFFSET;
                            state_next  = S_DONE;
                        end else begin
                            state_next  = S_FCHK;
                        end
                    end
                end
            end
            S_APOP: begin
                // pop head, mark page taken
                head_next[r_reg]   = link_rdata[PW-1:0];
                hvalid_next[r_reg] = link_rdata[PW];
                meta_we    = 1'b1;
                meta_waddr = p_reg;
                meta_wdata = {1'b0, (r_reg > rel_reg) ?
                              OW'(PAGE_SHIFT) + OW'(rel_reg) : meta_ord};
                state_next = (r_reg > rel_reg) ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                // upper half goes onto the next lower list
                bud        = p_reg ^ (PW'(1) << r_dec);
                meta_we    = 1'b1;
                meta_waddr = bud;
                meta_wdata = {1'b1, OW'(PAGE_SHIFT) + OW'(r_dec)};
                link_we    = 1'b1;
                link_waddr = bud;
                link_wdata = {hvalid_reg[r_dec], head_reg[r_dec]};
                head_next[r_dec]   = bud;
                hvalid_next[r_dec] = 1'b1;
                r_next     = r_dec;
                if (r_dec == rel_reg) state_next = S_DONE;
            end
            S_FCHK: begin
                priority if (meta_free) begin
                    status_next = ST_DOUBLE_FREE;
                    state_next  = S_DONE;
                end else if (meta_ord < OW'(PAGE_SHIFT) || meta_ord > OW'(MAXO)) begin
                    status_next = ST_BAD_OFFSET;
                    state_next  = S_DONE;
                end else begin
                    r_next     = RW'(meta_ord - OW'(PAGE_SHIFT));
                    meta_we    = 1'b1;
                    meta_waddr = p_reg;
                    meta_wdata = {1'b1, meta_ord};
                    state_next = S_FBUD;
                end
            end
            S_FBUD: begin
                if (r_reg >= RW'(TOP)) begin
                    state_next = S_PUSH;
                end else begin
                    b_next     = bud;
                    meta_raddr = bud;
                    state_next = S_FBCHK;
                end
            end
            S_FBCHK: begin
                if (!meta_free || meta_ord != OW'(PAGE_SHIFT) + OW'(r_reg)) begin
                    state_next = S_PUSH;
                end else begin
                    cur_next       = head_reg[r_reg];
                    ok_next        = hvalid_reg[r_reg];
                    have_prev_next = 1'b0;
                    steps_next     = '0;
                    state_next     = S_USTEP;
                end
            end
            S_USTEP: begin
                link_raddr = cur_reg;
                // buddy not found: merge goes on anyway
                state_next = (ok_reg && steps_reg < (PW+1)'(TOTAL_PAGES)) ?
                             S_UWAIT : S_MERGE;
            end
            S_UWAIT: begin
                if (cur_reg == b_reg) begin
                    if (have_prev_reg) begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                    end else begin
                        head_next[r_reg]   = link_rdata[PW-1:0];
                        hvalid_next[r_reg] = link_rdata[PW];
                    end
                    state_next = S_MERGE;
                end else begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    ok_next        = link_rdata[PW];
                    cur_next       = link_rdata[PW-1:0];
                    steps_next     = steps_reg + (PW+1)'(1);
                    state_next     = S_USTEP;
                end
            end
            S_MERGE: begin
                p_next     = (b_reg < p_reg) ? b_reg : p_reg;
                r_next     = r_reg + RW'(1);
                meta_we    = 1'b1;
                meta_waddr = (b_reg < p_reg) ? b_reg : p_reg;
                meta_wdata = {1'b1, OW'(PAGE_SHIFT) + OW'(r_reg) + OW'(1)};
                state_next = S_FBUD;
            end
            S_PUSH: begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = {hvalid_reg[r_reg], head_reg[r_reg]};
                head_next[r_reg]   = p_reg;
                hvalid_next[r_reg] = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {4'b0,
                                   (status_reg == ST_OK && func_reg == FUNC_ALLOC) ?
                                   off_wide[OFFSET_W-1:0] : {OFFSET_W{1'b0}},
                                   status_reg};
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i <= TOP; i++) head_reg[i] <= '0;
            hvalid_reg <= (TOP+1)'(1) << TOP;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
            head_reg   <= head_next;
            hvalid_reg <= hvalid_next;
        end
        p_reg         <= p_next;
        b_reg         <= b_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        ok_reg        <= ok_next;
        steps_reg     <= steps_next;
        r_reg         <= r_next;
        rel_reg       <= rel_next;
        func_reg      <= func_next;
        status_reg    <= status_next;
        mdata_reg     <= mdata_next;
    end
endmodule

FILE: sv/bpa_checker.sv
// Port-level assertions for the buddy page allocator, bound to the top level.
module bpa_checker
    import bpa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // failed requests carry no offset
    a_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[27:3] == '0)
        else $error("offset on failed request");

    // status code in range, padding bits zero
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_DOUBLE_FREE && m_tdata[31:28] == '0)
        else $error("bad status or padding");

    // clearing pass blocks requests right after reset
    a_clr: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready during clearing pass");

    // a taken request is not followed by another one the next cycle
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");
endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: test/buddy_page_allocator_core_tb.sv
// Testbench for the buddy page allocator core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module buddy_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int NPAGES     = 8192;
    localparam int PG_SHIFT   = 12;
    localparam int TOP_REL    = 13;          // log2(NPAGES)
    localparam int TOP_ORDER  = PG_SHIFT + TOP_REL;
    localparam int CYCLE_CAP  = 1500000;
    localparam int HOLD_LEN   = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    buddy_page_allocator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---------------------------------------------------------------
    // Allocator shadow: free-list heads, links, per-page order/free bit
    // ---------------------------------------------------------------
    logic [12:0] head_page [TOP_REL+1];
    bit          head_ok   [TOP_REL+1];
    logic [12:0] link_page [NPAGES];
    bit          link_ok   [NPAGES];
    logic [4:0]  blk_order [NPAGES];
    bit          blk_free  [NPAGES];

    // expected results, oldest first
    logic [2:0]  status_due [$];
    logic [24:0] offset_due [$];

    // offsets handed out and not yet returned, and ones already returned
    int unsigned live_blocks [$];
    int unsigned freed_blocks [$];

    bit  failed;
    bit  idle_on;       // sender gaps
    bit  stall_on;      // receiver stalls
    bit  hold_req;      // one long receiver hold-off
    int  cycles;

    // push a block onto the head of its order's list
    function automatic void list_push(input logic [12:0] p, input int r);
        link_page[p] = head_page[r];
        link_ok[p]   = head_ok[r];
        head_page[r] = p;
        head_ok[r]   = 1'b1;
    endfunction

    // remove a block from its list; walk bounded by the page count
    function automatic void list_unlink(input logic [12:0] b, input int r);
        bit          have_prev;
        logic [12:0] prev;
        logic [12:0] cur;
        bit          ok;
        int          steps;
        have_prev = 1'b0;
        prev      = '0;
        ok        = head_ok[r];
        cur       = head_page[r];
        steps     = 0;
        while (ok && steps < NPAGES) begin
            if (cur == b) begin
                if (have_prev) begin
                    link_page[prev] = link_page[cur];
                    link_ok[prev]   = link_ok[cur];
                end else begin
                    head_page[r] = link_page[cur];
                    head_ok[r]   = link_ok[cur];
                end
                return;
            end
            have_prev = 1'b1;
            prev      = cur;
            ok        = link_ok[cur];
            cur       = link_page[cur];
            steps++;
        end
    endfunction

    // compute the result of one request and update the shadow state
    function automatic void allocator_step(input logic func, input logic [31:0] req_bytes,
                                           input logic [31:0] offs,
                                           output logic [2:0] st, output logic [24:0] blk);
        int          o, rel, r;
        longint      t;
        logic [12:0] p, b;
        logic [31:0] pidx;
        st  = ST_OK;
        blk = '0;
        if (func == FUNC_ALLOC) begin
            o = 0;
            t = 1;
            while (t < longint'(req_bytes)) begin
                t = t << 1;
                o++;
            end
            if (o < PG_SHIFT) o = PG_SHIFT;
            if (req_bytes == 0) begin
                st = ST_ZERO_SIZE;
            end else if (o > TOP_ORDER) begin
                st = ST_TOO_LARGE;
            end else begin
                rel = o - PG_SHIFT;
                r   = rel;
                while (r <= TOP_REL && !head_ok[r]) r++;
                if (r > TOP_REL) begin
                    st = ST_NO_MEMORY;
                end else begin
                    p            = head_page[r];
                    head_page[r] = link_page[p];
                    head_ok[r]   = link_ok[p];
                    blk_free[p]  = 1'b0;
                    // split down, upper halves go back on the lists
                    while (r > rel) begin
                        r--;
                        b            = p ^ (13'd1 << r);
                        blk_order[p] = 5'(PG_SHIFT + r);
                        blk_order[b] = 5'(PG_SHIFT + r);
                        blk_free[b]  = 1'b1;
                        list_push(b, r);
                    end
                    blk = 25'(p) << PG_SHIFT;
                end
            end
        end else begin
            pidx = offs >> PG_SHIFT;
            if (pidx >= NPAGES) begin
                st = ST_BAD_OFFSET;
            end else begin
                p = pidx[12:0];
                if (blk_free[p]) begin
                    st = ST_DOUBLE_FREE;
                end else if (blk_order[p] < PG_SHIFT || blk_order[p] > TOP_ORDER) begin
                    st = ST_BAD_OFFSET;
                end else begin
                    r           = blk_order[p] - PG_SHIFT;
                    blk_free[p] = 1'b1;
                    // merge upward while the buddy is a free block of the same order
                    while (r < TOP_REL) begin
                        b = p ^ (13'd1 << r);
                        if (!blk_free[b] || blk_order[b] != 5'(PG_SHIFT + r)) break;
                        list_unlink(b, r);
                        if (b < p) p = b;
                        r++;
                        blk_order[p] = 5'(PG_SHIFT + r);
                    end
                    list_push(p, r);
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result side: m_tready pattern and checker
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // long hold-off so the core backs up and drops s_tready
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                $error("unexpected result: status %0d block_offset 0x%0h",
                       m_tdata[2:0], m_tdata[27:3]);
                failed = 1'b1;
            end else begin
                if (m_tdata[2:0] !== status_due[0]) begin
                    $error("status: expected %0d, got %0d", status_due[0], m_tdata[2:0]);
                    failed = 1'b1;
                end
                if (m_tdata[27:3] !== offset_due[0]) begin
                    $error("block_offset: expected 0x%0h, got 0x%0h",
                           offset_due[0], m_tdata[27:3]);
                    failed = 1'b1;
                end
                void'(status_due.pop_front());
                void'(offset_due.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // s_tvalid stays high between back-to-back requests; it only drops for a gap
    task automatic send_request(input logic func, input logic [31:0] req_bytes,
                                input logic [31:0] offs);
        logic [2:0]  st;
        logic [24:0] blk;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {offs, req_bytes};
        do @(posedge aclk); while (!s_tready);
        allocator_step(func, req_bytes, offs, st, blk);
        status_due.push_back(st);
        offset_due.push_back(blk);
        if (func == FUNC_ALLOC && st == ST_OK) begin
            live_blocks.push_back(blk);
        end else if (func == FUNC_FREE && st == ST_OK) begin
            foreach (live_blocks[i]) begin
                if (live_blocks[i] == (offs & 32'hFFFF_F000)) begin
                    live_blocks.delete(i);
                    break;
                end
            end
            freed_blocks.push_back(offs & 32'hFFFF_F000);
            if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
        end
    endtask

    // one random request: mostly well-formed alloc/free pairs, some noise
    task automatic random_request();
        int          sel;
        int          k;
        logic [31:0] sz;
        logic [31:0] off;
        sel = $urandom_range(0, 99);
        if (live_blocks.size() > 150 && sel < 50) sel = 60;
        if (sel < 50) begin
            if ($urandom_range(0, 19) == 0) sz = $urandom;
            else sz = $urandom_range(1, 32'd1 << $urandom_range(0, 17));
            send_request(FUNC_ALLOC, sz, $urandom);
        end else if (sel < 88 && live_blocks.size() > 0) begin
            k   = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[k];
            if ($urandom_range(0, 7) == 0) off = off | $urandom_range(1, 4095);
            send_request(FUNC_FREE, $urandom, off);
        end else if (sel < 94 && freed_blocks.size() > 0) begin
            k = $urandom_range(0, freed_blocks.size() - 1);
            send_request(FUNC_FREE, $urandom, freed_blocks[k]);
        end else if (sel < 97) begin
            send_request(FUNC_FREE, $urandom, $urandom);
        end else begin
            send_request(FUNC_FREE, $urandom, $urandom_range(0, 32'h01FF_FFFF));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send_request(FUNC_ALLOC, 32'd0, 32'd0);              // zero size
        send_request(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'h0200_0001, 32'd0);      // just over the region
        send_request(FUNC_ALLOC, 32'h0200_0000, 32'd0);      // whole region
        send_request(FUNC_ALLOC, 32'd1, 32'd0);              // nothing left
        send_request(FUNC_FREE,  32'd0, 32'd0);
        send_request(FUNC_FREE,  32'd0, 32'h0200_0000);      // past region
        send_request(FUNC_FREE,  32'd0, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'd8192, 32'd0);           // two pages at 0
        send_request(FUNC_FREE,  32'd0, 32'h0000_1000);      // page inside a block
        send_request(FUNC_FREE,  32'd0, 32'h0000_2000);      // free buddy: double free
        send_request(FUNC_ALLOC, 32'd1, 32'd0);
        send_request(FUNC_ALLOC, 32'd4096, 32'd0);
        send_request(FUNC_ALLOC, 32'd4097, 32'd0);
        send_request(FUNC_FREE,  32'd0, 32'h0000_2123);      // unaligned offset
        send_request(FUNC_FREE,  32'd0, 32'h0000_0FFF);
        send_request(FUNC_FREE,  32'd0, 32'h0000_3000);
        send_request(FUNC_FREE,  32'd0, 32'h0000_3000);      // again: double free
        send_request(FUNC_FREE,  32'd0, 32'h0000_4000);
        send_request(FUNC_FREE,  32'd0, 32'd0);              // double free: region already whole again
        send_request(FUNC_ALLOC, 32'h0100_0000, 32'd0);
        send_request(FUNC_ALLOC, 32'h0100_0000, 32'd0);
        send_request(FUNC_FREE,  32'd0, 32'h0100_0000);
        send_request(FUNC_FREE,  32'd0, 32'd0);
    endtask

    task automatic test_random(input int n);
        repeat (n) random_request();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (20) random_request();
    endtask

    task automatic test_full_rate();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        repeat (100) random_request();
    endtask

    initial begin
        int waited;
        failed   = 1'b0;
        cycles   = 0;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        hold_req = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = FUNC_ALLOC;
        s_tdata  = '0;
        m_tready = 1'b0;
        for (int i = 0; i <= TOP_REL; i++) begin
            head_page[i] = '0;
            head_ok[i]   = 1'b0;
        end
        for (int i = 0; i < NPAGES; i++) begin
            link_page[i] = '0;
            link_ok[i]   = 1'b0;
            blk_order[i] = '0;
            blk_free[i]  = 1'b0;
        end
        head_ok[TOP_REL] = 1'b1;
        blk_order[0]     = 5'(TOP_ORDER);
        blk_free[0]      = 1'b1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(300);
        test_backpressure();
        test_random(330);
        test_full_rate();

        @(posedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (status_due.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (64) @(posedge aclk);

        if (!failed && status_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/buddy_page_allocator_core.sv
sv/bpa_checker.sv
test/buddy_page_allocator_core_tb.sv
